### sv/partition_pair_score_scheduler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the partition pair score scheduler
// Concurrent checks sampled on the rising clock edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef PARTITION_PAIR_SCORE_SCHEDULER_ASSERT_SVH
`define PARTITION_PAIR_SCORE_SCHEDULER_ASSERT_SVH

// Same-cycle implication
`define PPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pps: same-cycle check failed");

// Next-cycle implication
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pps: next-cycle check failed");

`endif

### sv/pps_pkg.sv
// ---------------------------------------------------------------------------
// pps_pkg
// Widths, codes and shared types of the partition pair score scheduler.
// ---------------------------------------------------------------------------
package pps_pkg;

	// Table geometry
	localparam int MAX_PARTITIONS = 32;
	localparam int IDX_W          = 5;
	localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);
	localparam int ADDR_W         = 2 * IDX_W;

	// Field widths
	localparam int CMD_W   = 3;
	localparam int CFG_W   = 6;
	localparam int SCORE_W = 24;
	localparam int SUM_W   = SCORE_W + 1;

	// Q8.16 constants
	localparam logic signed [SCORE_W-1:0] SCORE_ONE  = 24'sd65536;
	localparam logic signed [SCORE_W-1:0] SCORE_ZERO = 24'sd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_SCORE = 3'd0,
		CMD_WR_PEND  = 3'd1,
		CMD_ADJ_PAIR = 3'd2,
		CMD_ADJ_ROW  = 3'd3,
		CMD_SELECT   = 3'd4,
		CMD_COPY     = 3'd5,
		CMD_READ     = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_POS  = 2'd1,
		CLS_NEG  = 2'd2
	} pend_class_t;

	// Memory requests from the sequencer; both tables share the read address
	typedef struct packed {
		logic                       score_we;
		logic [ADDR_W-1:0]          score_waddr;
		logic signed [SCORE_W-1:0]  score_wdata;
		logic                       pend_we;
		logic [ADDR_W-1:0]          pend_waddr;
		pend_class_t                pend_wdata;
		logic [ADDR_W-1:0]          raddr;
	} mem_req_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0]  score_rdata;
		pend_class_t                pend_rdata;
	} mem_rsp_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0]  score_out;
		logic                       pair_found;
		logic [IDX_W-1:0]           pair_first;
		logic [IDX_W-1:0]           pair_second;
	} result_t;

endpackage

### sv/pps_if.sv
// ---------------------------------------------------------------------------
// pps_in_if / pps_out_if
// Valid/ready channels carrying command items and result items.
// ---------------------------------------------------------------------------
interface pps_in_if;
	import pps_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           command;
	logic [IDX_W-1:0]           first_index;
	logic [IDX_W-1:0]           second_index;
	logic signed [SCORE_W-1:0]  value;

	modport source (
		output valid, command, first_index, second_index, value,
		input  ready
	);
	modport sink (
		input  valid, command, first_index, second_index, value,
		output ready
	);
endinterface

interface pps_out_if;
	import pps_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SCORE_W-1:0]  score_out;
	logic                       pair_found;
	logic [IDX_W-1:0]           pair_first;
	logic [IDX_W-1:0]           pair_second;

	modport source (
		output valid, score_out, pair_found, pair_first, pair_second,
		input  ready
	);
	modport sink (
		input  valid, score_out, pair_found, pair_first, pair_second,
		output ready
	);
endinterface

### sv/pps_ram.sv
// ---------------------------------------------------------------------------
// pps_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pps_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### sv/pps_engine.sv
// ---------------------------------------------------------------------------
// pps_engine
// Command sequencer: read-modify-write over the score and pending tables,
// row walks for adjust and copy, and the pair scan for select.
// ---------------------------------------------------------------------------
`include "partition_pair_score_scheduler_assert.svh"

module pps_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	pps_in_if.sink                   in_ch,
	input  logic [pps_pkg::CNT_W-1:0] bound,
	output pps_pkg::mem_req_t        mem_req,
	input  pps_pkg::mem_rsp_t        mem_rsp,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output pps_pkg::result_t         rsp
);
	import pps_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b0_0000_0001,
		S_IDLE   = 9'b0_0000_0010,
		S_RD_ISS = 9'b0_0000_0100,
		S_RD_CAP = 9'b0_0000_1000,
		S_PR_RD  = 9'b0_0001_0000,
		S_PR_WR  = 9'b0_0010_0000,
		S_ROW    = 9'b0_0100_0000,
		S_SEL    = 9'b0_1000_0000,
		S_RESP   = 9'b1_0000_0000
	} state_t;

	state_t                     state_q;
	logic [ADDR_W-1:0]          clr_q;
	cmd_t                       cmd_q;
	logic [IDX_W-1:0]           p_q;
	logic [IDX_W-1:0]           q_q;
	logic                       second_q;
	logic [CNT_W-1:0]           col_q;
	logic [CNT_W-1:0]           i_q;
	logic [CNT_W-1:0]           j_q;
	logic                       phase_q;
	logic signed [SCORE_W-1:0]  score_a_q;
	pend_class_t                pend_a_q;
	logic signed [SUM_W-1:0]    best_q;
	logic [IDX_W-1:0]           best_first_q;
	logic [IDX_W-1:0]           best_second_q;
	result_t                    rsp_q;

	// Read tags, aligned with the RAM output
	logic                       rd_vld_s1;
	logic                       rd_ph_s1;
	logic [IDX_W-1:0]           rd_i_s1;
	logic [IDX_W-1:0]           rd_j_s1;
	logic [IDX_W-1:0]           rd_col_s1;

	logic                       accept;
	cmd_t                       in_cmd;
	pend_class_t                in_class;
	logic [ADDR_W-1:0]          pr_addr;
	logic [ADDR_W-1:0]          sel_addr;
	logic [IDX_W-1:0]           dest_row;
	logic                       row_issue;
	logic                       sel_issue;
	logic signed [SCORE_W-1:0]  rd_score;
	pend_class_t                rd_pend;
	logic signed [SCORE_W-1:0]  pair_new;
	logic signed [SCORE_W-1:0]  row_new;
	logic signed [SUM_W-1:0]    sel_sum;
	logic                       sel_take;
	logic [CNT_W-1:0]           j_next;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_cmd      = cmd_t'(in_ch.command);

	assign rd_score = mem_rsp.score_rdata;
	assign rd_pend  = mem_rsp.pend_rdata;

	assign pr_addr   = second_q ? {q_q, p_q} : {p_q, q_q};
	assign sel_addr  = phase_q ? {j_q[IDX_W-1:0], i_q[IDX_W-1:0]}
	                           : {i_q[IDX_W-1:0], j_q[IDX_W-1:0]};
	assign dest_row  = (cmd_q == CMD_COPY) ? q_q : p_q;
	assign row_issue = (state_q == S_ROW) && (col_q < bound);
	assign sel_issue = (state_q == S_SEL) && (j_q < bound);
	assign j_next    = j_q + CNT_W'(1);

	// Keep only the sign class of a pending value
	always_comb begin
		if (in_ch.value > SCORE_ZERO) begin
			in_class = CLS_POS;
		end else if (in_ch.value < SCORE_ZERO) begin
			in_class = CLS_NEG;
		end else begin
			in_class = CLS_ZERO;
		end
	end

	// Pair adjust rule for one entry
	always_comb begin
		pair_new = rd_score;
		if (rd_pend == CLS_POS && rd_score < SCORE_ONE) begin
			pair_new = rd_score + SCORE_ONE;
		end else if (rd_pend == CLS_ZERO && rd_score > SCORE_ONE) begin
			pair_new = rd_score - SCORE_ONE;
		end
	end

	// Row adjust rule for one entry
	always_comb begin
		row_new = rd_score;
		if (rd_score > SCORE_ZERO && rd_score < SCORE_ONE) begin
			row_new = rd_score + SCORE_ONE;
		end else if (rd_score > SCORE_ONE) begin
			row_new = rd_score - SCORE_ONE;
		end
	end

	// Mirrored sum against the running best
	assign sel_sum  = SUM_W'(score_a_q) + SUM_W'(rd_score);
	assign sel_take = (state_q == S_SEL) && rd_vld_s1 && rd_ph_s1
		&& !(pend_a_q == CLS_ZERO && rd_pend == CLS_ZERO)
		&& (sel_sum > best_q);

	// Memory port steering
	always_comb begin
		mem_req = '0;
		if (state_q == S_CLEAR) begin
			mem_req.pend_we    = 1'b1;
			mem_req.pend_waddr = clr_q;
			mem_req.pend_wdata = CLS_ZERO;
		end
		if (accept && in_cmd == CMD_WR_PEND) begin
			mem_req.pend_we    = 1'b1;
			mem_req.pend_waddr = {in_ch.first_index, in_ch.second_index};
			mem_req.pend_wdata = in_class;
		end
		if (accept && in_cmd == CMD_WR_SCORE) begin
			mem_req.score_we    = 1'b1;
			mem_req.score_waddr = {in_ch.first_index, in_ch.second_index};
			mem_req.score_wdata = in_ch.value;
		end
		if (state_q == S_PR_WR) begin
			mem_req.score_we    = 1'b1;
			mem_req.score_waddr = pr_addr;
			mem_req.score_wdata = pair_new;
		end
		if (state_q == S_ROW && rd_vld_s1) begin
			mem_req.score_we    = 1'b1;
			mem_req.score_waddr = {dest_row, rd_col_s1};
			mem_req.score_wdata = (cmd_q == CMD_COPY) ? rd_score : row_new;
		end
		unique case (state_q)
			S_RD_ISS: mem_req.raddr = {p_q, q_q};
			S_PR_RD:  mem_req.raddr = pr_addr;
			S_ROW:    mem_req.raddr = {p_q, col_q[IDX_W-1:0]};
			S_SEL:    mem_req.raddr = sel_addr;
			default:  mem_req.raddr = '0;
		endcase
	end

	assign rsp_valid = (state_q == S_RESP);
	assign rsp       = rsp_q;

	// Control: sequencer state, clearing pass, read tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= row_issue || sel_issue;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (in_cmd)
							CMD_READ:             state_q <= S_RD_ISS;
							CMD_ADJ_PAIR:         state_q <= S_PR_RD;
							CMD_ADJ_ROW, CMD_COPY: state_q <= S_ROW;
							CMD_SELECT:           state_q <= S_SEL;
							default:              state_q <= S_RESP;
						endcase
					end
				end
				S_RD_ISS: state_q <= S_RD_CAP;
				S_RD_CAP: state_q <= S_RESP;
				S_PR_RD:  state_q <= S_PR_WR;
				S_PR_WR: begin
					state_q <= second_q ? S_RESP : S_PR_RD;
				end
				S_ROW: begin
					if (!row_issue && !rd_vld_s1) begin
						state_q <= S_RESP;
					end
				end
				S_SEL: begin
					if (!sel_issue && !rd_vld_s1) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: command capture, walk counters, scan best, result
	always_ff @(posedge clk) begin
		rd_ph_s1  <= phase_q;
		rd_i_s1   <= i_q[IDX_W-1:0];
		rd_j_s1   <= j_q[IDX_W-1:0];
		rd_col_s1 <= col_q[IDX_W-1:0];

		if (accept) begin
			cmd_q         <= in_cmd;
			p_q           <= in_ch.first_index;
			q_q           <= in_ch.second_index;
			second_q      <= 1'b0;
			col_q         <= '0;
			i_q           <= '0;
			j_q           <= CNT_W'(1);
			phase_q       <= 1'b0;
			best_q        <= '0;
			best_first_q  <= '0;
			best_second_q <= '0;
			rsp_q         <= '0;
		end

		// Second entry of a pair adjust
		if (state_q == S_PR_WR) begin
			second_q <= 1'b1;
		end

		// Read result
		if (state_q == S_RD_CAP) begin
			rsp_q.score_out <= rd_score;
		end

		// Advance the row walk
		if (row_issue) begin
			col_q <= col_q + CNT_W'(1);
		end

		// Advance the pair scan: two reads per pair, then the next j or row
		if (sel_issue) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				if (j_next < bound) begin
					j_q <= j_next;
				end else begin
					i_q <= i_q + CNT_W'(1);
					j_q <= i_q + CNT_W'(2);
				end
			end
		end

		// Hold the first half of a pair
		if (state_q == S_SEL && rd_vld_s1 && !rd_ph_s1) begin
			score_a_q <= rd_score;
			pend_a_q  <= rd_pend;
		end

		// Keep the first strictly greatest sum
		if (sel_take) begin
			best_q        <= sel_sum;
			best_first_q  <= rd_i_s1;
			best_second_q <= rd_j_s1;
		end

		// Finish select
		if (state_q == S_SEL && !sel_issue && !rd_vld_s1) begin
			rsp_q.pair_found  <= !best_q[SUM_W-1] && (best_q != '0);
			rsp_q.pair_first  <= best_first_q;
			rsp_q.pair_second <= best_second_q;
		end
	end

	`PPS_ASSERT_NOW(a_idle_no_write, clk, arst_n, state_q == S_IDLE && !accept, !mem_req.score_we && !mem_req.pend_we)
	`PPS_ASSERT_NOW(a_sel_read_only, clk, arst_n, state_q == S_SEL, !mem_req.score_we && !mem_req.pend_we)
	`PPS_ASSERT_NOW(a_row_in_bound, clk, arst_n, state_q == S_ROW, col_q <= bound)
	`PPS_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != S_IDLE)
endmodule

### sv/partition_pair_score_scheduler.sv
// Throughput: one item at a time; the pair scan issues one table read per cycle,
//   two per pair, so select dominates.
// Reset: the partition count clears to 0; the pending table is swept to the zero
//   class, during which no item is taken. Scores are not reset.
// ---------------------------------------------------------------------------
// partition_pair_score_scheduler
// Pair score and pending class tables in RAM with a command sequencer and a
// registered result stage.
// ---------------------------------------------------------------------------
module partition_pair_score_scheduler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [pps_pkg::CFG_W-1:0] cfg_wr_data,
	pps_in_if.sink                    in_ch,
	pps_out_if.source                 out_ch
);
	import pps_pkg::*;

	logic [CNT_W-1:0]           bound_q;
	logic                       out_valid_q;
	result_t                    out_q;

	mem_req_t                   mem_req;
	mem_rsp_t                   mem_rsp;
	logic                       rsp_valid;
	logic                       rsp_ready;
	result_t                    rsp;
	logic [SCORE_W-1:0]         score_rdata;
	logic [1:0]                 pend_rdata;

	// Partition count, saturated to the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data > CFG_W'(MAX_PARTITIONS)) begin
				bound_q <= CNT_W'(MAX_PARTITIONS);
			end else begin
				bound_q <= CNT_W'(cfg_wr_data);
			end
		end
	end

	pps_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.bound     (bound_q),
		.mem_req   (mem_req),
		.mem_rsp   (mem_rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	pps_ram #(
		.WIDTH  (SCORE_W),
		.ADDR_W (ADDR_W)
	) u_score_ram (
		.clk   (clk),
		.we    (mem_req.score_we),
		.waddr (mem_req.score_waddr),
		.wdata (mem_req.score_wdata),
		.raddr (mem_req.raddr),
		.rdata (score_rdata)
	);

	pps_ram #(
		.WIDTH  (2),
		.ADDR_W (ADDR_W)
	) u_pend_ram (
		.clk   (clk),
		.we    (mem_req.pend_we),
		.waddr (mem_req.pend_waddr),
		.wdata (mem_req.pend_wdata),
		.raddr (mem_req.raddr),
		.rdata (pend_rdata)
	);

	assign mem_rsp.score_rdata = score_rdata;
	assign mem_rsp.pend_rdata  = pend_class_t'(pend_rdata);

	// Result register: take a new result when empty or draining
	assign rsp_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			out_q <= rsp;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.score_out   = out_q.score_out;
	assign out_ch.pair_found  = out_q.pair_found;
	assign out_ch.pair_first  = out_q.pair_first;
	assign out_ch.pair_second = out_q.pair_second;
endmodule
